// ----- design/psf_pkg.sv -----
`default_nettype none
package psf_pkg;

   localparam int MAX_OUT = 32;
   localparam int KW = $clog2(MAX_OUT + 1);

   localparam logic [1:0] ST_SPAN  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_NONE  = 2'd2;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_APPEND,
      OP_SORT,
      OP_ROTATE
   } psf_op_type;

   typedef struct packed {
      psf_op_type op;
      logic       phase;
   } psf_cmd_type;

endpackage
`default_nettype wire

// ----- design/psf_req_if.sv -----
`default_nettype none
interface psf_req_if #(parameter int COORD_BITS = 12) ();
   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [COORD_BITS-1:0] vert_x;
   logic [COORD_BITS-1:0] vert_y;
   logic                  last_vertex;

   modport source (output valid, func, vert_x, vert_y, last_vertex, input ready);
   modport sink (input valid, func, vert_x, vert_y, last_vertex, output ready);
endinterface
`default_nettype wire

// ----- design/psf_rsp_if.sv -----
`default_nettype none
interface psf_rsp_if #(parameter int COORD_BITS = 12) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] line_y;
   logic [COORD_BITS-1:0] span_left;
   logic [COORD_BITS-1:0] span_right;
   logic [1:0]            status;
   logic                  last_of_line;

   modport source (output valid, line_y, span_left, span_right, status, last_of_line,
                   input ready);
   modport sink (input valid, line_y, span_left, span_right, status, last_of_line,
                 output ready);
endinterface
`default_nettype wire

// ----- design/psf_div.sv -----
`default_nettype none
module psf_div import psf_pkg::*; #(
   parameter int NB = 28,
   parameter int DB = 12
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NB-1:0] num,
   input  wire logic [DB-1:0] den,
   output logic               done,
   output logic [NB-1:0]      quo
);
   localparam int CB = $clog2(NB + 1);

   logic [DB-1:0] rem_ff, rem_in;
   logic [NB-1:0] quo_ff, quo_in;
   logic [DB-1:0] den_ff;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [DB:0]   trial;

   always_comb begin
      trial = {rem_ff, quo_ff[NB-1]};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = num;
         cnt_in = CB'(NB);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DB'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = trial[DB-1:0];
            quo_in = {quo_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == CB'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quo = quo_ff;
endmodule
`default_nettype wire

// ----- design/psf_cell.sv -----
`default_nettype none
module psf_cell import psf_pkg::*; #(
   parameter int INDEX = 0,
   parameter int LAST = 1,
   parameter int XW = 29,
   parameter int CW = 12,
   parameter int TW = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire psf_cmd_type   cmd,
   input  wire logic [CW-1:0] line,
   input  wire logic [TW-1:0] tail,
   input  wire logic [XW-1:0] new_x,
   input  wire logic [XW-1:0] new_s,
   input  wire logic [CW-1:0] new_top,
   input  wire logic          left_v,
   input  wire logic [XW-1:0] left_x,
   input  wire logic [XW-1:0] left_s,
   input  wire logic [CW-1:0] left_top,
   input  wire logic          right_v,
   input  wire logic [XW-1:0] right_x,
   input  wire logic [XW-1:0] right_s,
   input  wire logic [CW-1:0] right_top,
   output logic               own_v,
   output logic [XW-1:0]      own_x,
   output logic [XW-1:0]      own_s,
   output logic [CW-1:0]      own_top
);
   logic          v_ff, v_in;
   logic [XW-1:0] x_ff, x_in, s_ff, s_in;
   logic [CW-1:0] top_ff, top_in;
   logic [XW:0]   sum;

   function automatic logic goes_first(input logic av, input logic [XW-1:0] ax,
                                       input logic [XW-1:0] as, input logic bv,
                                       input logic [XW-1:0] bx, input logic [XW-1:0] bs);
      return av && (!bv || ($signed(ax) < $signed(bx)) ||
                    ((ax == bx) && ($signed(as) < $signed(bs))));
   endfunction

   always_comb begin
      v_in = v_ff;
      x_in = x_ff;
      s_in = s_ff;
      top_in = top_ff;
      sum = {right_x[XW-1], right_x} + {right_s[XW-1], right_s};
      case (cmd.op)
         OP_CLEAR: begin
            v_in = 1'b0;
         end
         OP_APPEND: begin
            if (tail == TW'(INDEX)) begin
               v_in = 1'b1;
               x_in = new_x;
               s_in = new_s;
               top_in = new_top;
            end
         end
         OP_SORT: begin
            if (cmd.phase == 1'(INDEX % 2)) begin
               if (INDEX < LAST &&
                   goes_first(right_v, right_x, right_s, v_ff, x_ff, s_ff)) begin
                  v_in = right_v;
                  x_in = right_x;
                  s_in = right_s;
                  top_in = right_top;
               end
            end else if (INDEX > 0 &&
                         goes_first(v_ff, x_ff, s_ff, left_v, left_x, left_s)) begin
               v_in = left_v;
               x_in = left_x;
               s_in = left_s;
               top_in = left_top;
            end
         end
         OP_ROTATE: begin
            v_in = right_v;
            x_in = right_x;
            s_in = right_s;
            top_in = right_top;
            if (INDEX == LAST) begin
               v_in = right_v && (right_top > line);
               if (sum[XW] != sum[XW-1]) begin
                  x_in = sum[XW] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
               end else begin
                  x_in = sum[XW-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      x_ff <= x_in;
      s_ff <= s_in;
      top_ff <= top_in;
   end

   assign own_v = v_ff;
   assign own_x = x_ff;
   assign own_s = s_ff;
   assign own_top = top_ff;
endmodule
`default_nettype wire

// ----- design/polygon_scanline_fill.sv -----
// A vertex word is stored as it is accepted, and the next word can be accepted on the next cycle.
// A scanline request is accepted, reads every vertex, visits both edges at each vertex
// on the line and computes the slope of each new edge (serial slope divider), then runs
// the odd-even sort, the rotation through the edge cells that emits one span word per
// pair, and the closing step. The rotation holds while a span word waits on the output.
// Requests are handled one at a time. Synchronous reset empties the vertex count, the
// edge cells and the output register.
`default_nettype none
module polygon_scanline_fill import psf_pkg::*; #(
   parameter int MAX_VERTS = 64,
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   psf_req_if.sink   req_ch,
   psf_rsp_if.source rsp_ch
);
   localparam int CW = COORD_BITS;
   localparam int NB = COORD_BITS + FRAC_BITS;
   localparam int XW = NB + 1;
   localparam int IW = $clog2(MAX_VERTS);
   localparam int TW = $clog2(MAX_VERTS + 1);
   localparam int LAST = MAX_VERTS - 1;

   typedef enum logic [3:0] {
      S_IDLE, S_NOPOLY, S_VREAD, S_VJ, S_RA, S_GA, S_RB, S_GB, S_DIV, S_NEXT,
      S_SORT, S_ROT, S_END
   } state_type;

   state_type     state_ff;
   logic [TW-1:0] total_ff, tail_ff, eff_total;
   logic          closed_ff;
   logic [CW-1:0] run_lo_ff, run_hi_ff, high_ff, scan_ff;
   logic [IW-1:0] j_ff, r_ff, sort_ff;
   logic          side_ff, neg_ff, xav_ff;
   logic [CW-1:0] xj_ff, xa_ff, ya_ff, etop_ff;
   logic [XW-1:0] sxa_ff;
   logic [KW-1:0] k_ff;
   logic          rsp_valid_ff;
   logic [CW-1:0] line_y_ff, left_ff, right_ff;
   logic [1:0]    status_ff;
   logic          lol_ff;

   logic [2*CW-1:0] vmem [MAX_VERTS];
   logic [2*CW-1:0] mem_q_ff;
   logic [IW-1:0]   rd_addr, last_idx, p_idx, pp_idx, q_idx, qq_idx;
   logic            mem_we, load_go, scan_go, out_free, rsp_set;
   logic [CW-1:0]   vx_q, vy_q, nlo, nhi;

   logic [CW:0]     dx;
   logic [CW-1:0]   mag, dy;
   logic [NB-1:0]   num, quo;
   logic            div_start, div_done;
   logic [XW-1:0]   new_x, new_s, sq;

   psf_cmd_type     cmd;
   logic            cv [MAX_VERTS];
   logic [XW-1:0]   cx [MAX_VERTS];
   logic [XW-1:0]   cs [MAX_VERTS];
   logic [CW-1:0]   ct [MAX_VERTS];

   logic            emit_now, emit_last, stall;
   logic signed [XW-1:0] xa_sh;
   logic signed [XW:0]   diff, diff_sh;
   logic signed [CW:0]   span_l;
   logic signed [CW+1:0] span_d;
   logic signed [CW+2:0] span_l_ext, span_r;

   function automatic logic [CW-1:0] clamp(input logic signed [CW+2:0] v);
      if (v < 0) begin
         return '0;
      end else if (v > $signed({3'b000, {CW{1'b1}}})) begin
         return {CW{1'b1}};
      end else begin
         return v[CW-1:0];
      end
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign load_go = (state_ff == S_IDLE) && req_ch.valid && !req_ch.func;
   assign scan_go = (state_ff == S_IDLE) && req_ch.valid && req_ch.func;
   assign eff_total = closed_ff ? '0 : total_ff;
   assign mem_we = load_go && (eff_total < TW'(MAX_VERTS));
   assign vx_q = mem_q_ff[2*CW-1:CW];
   assign vy_q = mem_q_ff[CW-1:0];

   always_comb begin
      if (eff_total == '0) begin
         nlo = req_ch.vert_y;
         nhi = req_ch.vert_y;
      end else begin
         nlo = (req_ch.vert_y < run_lo_ff) ? req_ch.vert_y : run_lo_ff;
         nhi = (req_ch.vert_y > run_hi_ff) ? req_ch.vert_y : run_hi_ff;
      end
   end

   always_comb begin
      last_idx = IW'(total_ff - 1'b1);
      p_idx = (j_ff == '0) ? last_idx : j_ff - 1'b1;
      pp_idx = (p_idx == '0) ? last_idx : p_idx - 1'b1;
      q_idx = (j_ff == last_idx) ? '0 : j_ff + 1'b1;
      qq_idx = (q_idx == last_idx) ? '0 : q_idx + 1'b1;
      case (state_ff)
         S_RA: rd_addr = side_ff ? q_idx : p_idx;
         S_RB: rd_addr = side_ff ? qq_idx : pp_idx;
         default: rd_addr = j_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vmem[IW'(eff_total)] <= {req_ch.vert_x, req_ch.vert_y};
      end
      mem_q_ff <= vmem[rd_addr];
   end

   always_comb begin
      dx = {1'b0, xa_ff} - {1'b0, xj_ff};
      mag = dx[CW] ? CW'(-dx) : dx[CW-1:0];
      dy = ya_ff - scan_ff;
      num = {mag, {FRAC_BITS{1'b0}}} + NB'(dy >> 1);
      div_start = (state_ff == S_GB) && (ya_ff > scan_ff);
      sq = {1'b0, quo};
      new_s = neg_ff ? -sq : sq;
      new_x = {1'b0, xj_ff, {FRAC_BITS{1'b0}}};
   end

   psf_div #(.NB(NB), .DB(CW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(num), .den(dy),
      .done(div_done), .quo(quo)
   );

   always_comb begin
      xa_sh = $signed(sxa_ff) >>> FRAC_BITS;
      span_l = xa_sh[CW:0];
      diff = $signed({cx[0][XW-1], cx[0]}) - $signed({sxa_ff[XW-1], sxa_ff});
      diff_sh = diff >>> FRAC_BITS;
      span_d = diff_sh[CW+1:0];
      span_l_ext = {{2{span_l[CW]}}, span_l};
      span_r = span_l_ext + {span_d[CW+1], span_d};
      emit_now = (state_ff == S_ROT) && r_ff[0] && xav_ff && cv[0] &&
                 (k_ff < KW'(MAX_OUT));
      emit_last = (k_ff == KW'(MAX_OUT - 1)) ||
                  !((((TW+1)'(r_ff) + (TW+1)'(2)) < (TW+1)'(MAX_VERTS)) && cv[2]);
      stall = emit_now && !out_free;
   end

   assign rsp_set = ((state_ff == S_NOPOLY) && out_free) || (emit_now && out_free) ||
                    ((state_ff == S_END) && (k_ff == '0) && out_free);

   always_comb begin
      cmd.op = OP_HOLD;
      cmd.phase = sort_ff[0];
      case (state_ff)
         S_IDLE: begin
            if (load_go && (closed_ff || req_ch.last_vertex)) begin
               cmd.op = OP_CLEAR;
            end
         end
         S_DIV: begin
            if (div_done) begin
               cmd.op = OP_APPEND;
            end
         end
         S_SORT: cmd.op = OP_SORT;
         S_ROT: begin
            if (!stall) begin
               cmd.op = OP_ROTATE;
            end
         end
         S_END: begin
            if ((k_ff != '0 || out_free) && scan_ff >= high_ff) begin
               cmd.op = OP_CLEAR;
            end
         end
         default: begin
         end
      endcase
   end

   for (genvar i = 0; i < MAX_VERTS; i++) begin : g_cell
      localparam int LI = (i == 0) ? 0 : i - 1;
      localparam int RI = (i == LAST) ? 0 : i + 1;
      psf_cell #(.INDEX(i), .LAST(LAST), .XW(XW), .CW(CW), .TW(TW)) u_cell (
         .clock(clock), .reset(reset), .cmd(cmd), .line(scan_ff), .tail(tail_ff),
         .new_x(new_x), .new_s(new_s), .new_top(etop_ff),
         .left_v(cv[LI]), .left_x(cx[LI]), .left_s(cs[LI]), .left_top(ct[LI]),
         .right_v(cv[RI]), .right_x(cx[RI]), .right_s(cs[RI]), .right_top(ct[RI]),
         .own_v(cv[i]), .own_x(cx[i]), .own_s(cs[i]), .own_top(ct[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         tail_ff <= '0;
         closed_ff <= 1'b0;
         scan_ff <= '0;
         high_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (load_go) begin
                  if (mem_we) begin
                     total_ff <= eff_total + 1'b1;
                     run_lo_ff <= nlo;
                     run_hi_ff <= nhi;
                  end else begin
                     total_ff <= eff_total;
                  end
                  if (req_ch.last_vertex) begin
                     high_ff <= mem_we ? nhi : run_hi_ff;
                     scan_ff <= mem_we ? nlo : run_lo_ff;
                     tail_ff <= '0;
                     closed_ff <= 1'b1;
                  end else if (closed_ff) begin
                     tail_ff <= '0;
                     closed_ff <= 1'b0;
                  end
               end else if (scan_go) begin
                  if (!closed_ff || total_ff == '0) begin
                     state_ff <= S_NOPOLY;
                  end else begin
                     j_ff <= '0;
                     state_ff <= S_VREAD;
                  end
               end
            end
            S_NOPOLY: begin
               if (out_free) begin
                  line_y_ff <= scan_ff;
                  left_ff <= '0;
                  right_ff <= '0;
                  status_ff <= ST_NONE;
                  lol_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_VREAD: state_ff <= S_VJ;
            S_VJ: begin
               xj_ff <= vx_q;
               side_ff <= 1'b0;
               if (vy_q == scan_ff) begin
                  state_ff <= S_RA;
               end else if (j_ff == last_idx) begin
                  sort_ff <= '0;
                  state_ff <= S_SORT;
               end else begin
                  j_ff <= j_ff + 1'b1;
                  state_ff <= S_VREAD;
               end
            end
            S_RA: state_ff <= S_GA;
            S_GA: begin
               xa_ff <= vx_q;
               ya_ff <= vy_q;
               state_ff <= S_RB;
            end
            S_RB: state_ff <= S_GB;
            S_GB: begin
               neg_ff <= dx[CW];
               etop_ff <= (vy_q > ya_ff) ? ya_ff - 1'b1 : ya_ff;
               state_ff <= div_start ? S_DIV : S_NEXT;
            end
            S_DIV: begin
               if (div_done) begin
                  tail_ff <= tail_ff + 1'b1;
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               if (!side_ff) begin
                  side_ff <= 1'b1;
                  state_ff <= S_RA;
               end else if (j_ff == last_idx) begin
                  sort_ff <= '0;
                  state_ff <= S_SORT;
               end else begin
                  j_ff <= j_ff + 1'b1;
                  state_ff <= S_VREAD;
               end
            end
            S_SORT: begin
               if (sort_ff == IW'(LAST)) begin
                  r_ff <= '0;
                  k_ff <= '0;
                  xav_ff <= 1'b0;
                  state_ff <= S_ROT;
               end else begin
                  sort_ff <= sort_ff + 1'b1;
               end
            end
            S_ROT: begin
               if (!stall) begin
                  if (!r_ff[0]) begin
                     sxa_ff <= cx[0];
                     xav_ff <= cv[0];
                  end else if (emit_now) begin
                     line_y_ff <= scan_ff;
                     left_ff <= clamp(span_l_ext);
                     right_ff <= clamp(span_r);
                     status_ff <= ST_SPAN;
                     lol_ff <= emit_last;
                     k_ff <= k_ff + 1'b1;
                  end
                  if (r_ff == IW'(LAST)) begin
                     state_ff <= S_END;
                  end else begin
                     r_ff <= r_ff + 1'b1;
                  end
               end
            end
            S_END: begin
               if (k_ff != '0 || out_free) begin
                  if (k_ff == '0) begin
                     line_y_ff <= scan_ff;
                     left_ff <= '0;
                     right_ff <= '0;
                     status_ff <= ST_EMPTY;
                     lol_ff <= 1'b1;
                  end
                  if (scan_ff >= high_ff) begin
                     closed_ff <= 1'b0;
                     total_ff <= '0;
                     tail_ff <= '0;
                  end else begin
                     scan_ff <= scan_ff + 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.line_y = line_y_ff;
   assign rsp_ch.span_left = left_ff;
   assign rsp_ch.span_right = right_ff;
   assign rsp_ch.status = status_ff;
   assign rsp_ch.last_of_line = lol_ff;
endmodule
`default_nettype wire
